/* hw/rtl/wbfbp_pkg.sv */
// ----------------------------------------------------------------------------
// Wear-bucketed free block pool package
// Default sizes, stream field layout and result status codes.
// ----------------------------------------------------------------------------
package wbfbp_pkg;

    localparam int LEVELS_DEF      = 16;
    localparam int LEVEL_DEPTH_DEF = 1024;
    localparam int BLOCK_BITS_DEF  = 16;
    localparam int MAX_REQUEST_DEF = 64;

    // Fixed field widths of the stream items.
    localparam int BLOCK_W  = 16;
    localparam int WEAR_W   = 4;
    localparam int REQ_W    = 7;
    localparam int STATUS_W = 2;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 16;

    localparam logic FUNC_PUT = 1'b0;
    localparam logic FUNC_GET = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_STORED  = 2'd0,
        ST_GRANTED = 2'd1,
        ST_DROPPED = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

endpackage

/* hw/rtl/wbfbp_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data that holds
// while no read is requested.
// ----------------------------------------------------------------------------
module wbfbp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/wear_bucketed_free_block_pool.sv */
// ----------------------------------------------------------------------------
// Wear-bucketed free block pool
// Free blocks kept in one LIFO stack per wear level; gets pop from the
// least worn levels first.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on the s_axis channel. tuser is the function (put or
//   get); tdata carries block number, wear level and request count. A put
//   gives one result item; a get gives one item per granted block, or one
//   pool-empty item when nothing is granted. Results leave on m_axis with
//   the status in tuser and tlast on the final item of each input item.
//   Items are taken one at a time. A put reads its level's fill count and
//   then, in S_PUT, stores the block and registers its result. A get reads
//   the fill count of each level scanned (S_GRD, S_GPOP), one stack memory
//   entry per granted block (S_GPOP, S_GDAT), and closes in S_GEND.
//   A one-item output register lets the next item be accepted while the
//   last result still waits. When the receiver stalls, the sequencer holds
//   its place until the output register frees up. Reset clears all fill
//   counts at once through per-level valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module wear_bucketed_free_block_pool #(
    parameter int LEVELS      = wbfbp_pkg::LEVELS_DEF,
    parameter int LEVEL_DEPTH = wbfbp_pkg::LEVEL_DEPTH_DEF,
    parameter int BLOCK_BITS  = wbfbp_pkg::BLOCK_BITS_DEF,
    parameter int MAX_REQUEST = wbfbp_pkg::MAX_REQUEST_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // block_in [15:0], wear_level [19:16], request_count [26:20], zero fill
    input  logic [wbfbp_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // func
    input  logic                                  i_s_axis_tuser,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // block_out [15:0]
    output logic [wbfbp_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    // status [1:0]
    output logic [wbfbp_pkg::STATUS_W-1:0]        o_m_axis_tuser,
    output logic                                  o_m_axis_tlast
);

    import wbfbp_pkg::*;

    localparam int SW = (BLOCK_BITS < BLOCK_W) ? BLOCK_BITS : BLOCK_W;
    localparam int LW = $clog2(LEVELS);
    localparam int FW = $clog2(LEVEL_DEPTH + 1);
    localparam int SDEPTH = LEVELS * LEVEL_DEPTH;
    localparam int AW = $clog2(SDEPTH);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PUT  = 6'b000010,
        S_GRD  = 6'b000100,
        S_GPOP = 6'b001000,
        S_GDAT = 6'b010000,
        S_GEND = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [SW-1:0]       r_blk, n_blk;
    logic [LW-1:0]       r_lvl, n_lvl;
    logic [REQ_W-1:0]    r_want, n_want;
    logic [FW-1:0]       r_fill, n_fill;
    logic [LEVELS-1:0]   r_fvld, n_fvld;
    logic                r_pv, n_pv;
    logic [SW-1:0]       r_pb, n_pb;
    logic                r_ov, n_ov;
    logic [BLOCK_W-1:0]  r_ob, n_ob;
    t_status             r_os, n_os;
    logic                r_ol, n_ol;

    logic                fill_we, fill_re;
    logic [LW-1:0]       fill_waddr, fill_raddr;
    logic [FW-1:0]       fill_wdata, fill_rdata, cur_fill;
    logic                stk_we, stk_re;
    logic [AW-1:0]       stk_waddr, stk_raddr, base;
    logic [SW-1:0]       stk_rdata;

    logic                accept, out_free;
    logic [BLOCK_W-1:0]  in_blk;
    logic [WEAR_W-1:0]   in_wear;
    logic [REQ_W-1:0]    in_req, req_sat;
    logic [LW-1:0]       lvl_sat;

    assign in_blk  = i_s_axis_tdata[BLOCK_W-1:0];
    assign in_wear = i_s_axis_tdata[BLOCK_W+WEAR_W-1:BLOCK_W];
    assign in_req  = i_s_axis_tdata[BLOCK_W+WEAR_W+REQ_W-1:BLOCK_W+WEAR_W];

    assign lvl_sat = (32'(in_wear) >= LEVELS) ? LW'(LEVELS - 1) : LW'(in_wear);
    assign req_sat = (32'(in_req) > MAX_REQUEST) ? REQ_W'(MAX_REQUEST) : in_req;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_ov || i_m_axis_tready;

    // A level whose fill count was never written since reset reads as empty.
    assign cur_fill = r_fvld[r_lvl] ? fill_rdata : '0;
    assign base     = AW'(r_lvl) * AW'(LEVEL_DEPTH);

    wbfbp_ram #(
        .WIDTH (FW),
        .DEPTH (LEVELS)
    ) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (fill_we),
        .i_waddr (fill_waddr),
        .i_wdata (fill_wdata),
        .i_re    (fill_re),
        .i_raddr (fill_raddr),
        .o_rdata (fill_rdata)
    );

    wbfbp_ram #(
        .WIDTH (SW),
        .DEPTH (SDEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (r_blk),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_blk      = r_blk;
        n_lvl      = r_lvl;
        n_want     = r_want;
        n_fill     = r_fill;
        n_fvld     = r_fvld;
        n_pv       = r_pv;
        n_pb       = r_pb;
        n_ov       = r_ov;
        n_ob       = r_ob;
        n_os       = r_os;
        n_ol       = r_ol;
        fill_we    = 1'b0;
        fill_re    = 1'b0;
        fill_waddr = r_lvl;
        fill_raddr = r_lvl;
        fill_wdata = r_fill;
        stk_we     = 1'b0;
        stk_re     = 1'b0;
        stk_waddr  = base + AW'(cur_fill);
        stk_raddr  = base + AW'(r_fill - 1'b1);

        if (r_ov && i_m_axis_tready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_s_axis_tuser == FUNC_PUT) begin
                        n_lvl      = lvl_sat;
                        n_blk      = in_blk[SW-1:0];
                        fill_re    = 1'b1;
                        fill_raddr = lvl_sat;
                        n_state    = S_PUT;
                    end else begin
                        n_want = req_sat;
                        n_lvl  = '0;
                        n_pv   = 1'b0;
                        if (req_sat == '0) begin
                            n_state = S_GEND;
                        end else begin
                            fill_re    = 1'b1;
                            fill_raddr = '0;
                            n_state    = S_GRD;
                        end
                    end
                end
            end
            S_PUT: begin
                if (out_free) begin
                    n_ov = 1'b1;
                    n_ob = '0;
                    n_ol = 1'b1;
                    if (cur_fill >= FW'(LEVEL_DEPTH)) begin
                        n_os = ST_DROPPED;
                    end else begin
                        stk_we        = 1'b1;
                        fill_we       = 1'b1;
                        fill_wdata    = cur_fill + 1'b1;
                        n_fvld[r_lvl] = 1'b1;
                        n_os          = ST_STORED;
                    end
                    n_state = S_IDLE;
                end
            end
            S_GRD: begin
                n_fill  = cur_fill;
                n_state = S_GPOP;
            end
            S_GPOP: begin
                if (r_want != '0 && r_fill != '0) begin
                    stk_re  = 1'b1;
                    n_fill  = r_fill - 1'b1;
                    n_want  = r_want - 1'b1;
                    n_state = S_GDAT;
                end else begin
                    // Level done: write back what is left of its stack.
                    fill_we       = 1'b1;
                    n_fvld[r_lvl] = 1'b1;
                    if (r_want == '0 || r_lvl == LW'(LEVELS - 1)) begin
                        n_state = S_GEND;
                    end else begin
                        n_lvl      = r_lvl + 1'b1;
                        fill_re    = 1'b1;
                        fill_raddr = r_lvl + 1'b1;
                        n_state    = S_GRD;
                    end
                end
            end
            S_GDAT: begin
                // The newest grant is held back until it is known whether it
                // is the final one.
                if (!r_pv || out_free) begin
                    if (r_pv) begin
                        n_ov = 1'b1;
                        n_ob = BLOCK_W'(r_pb);
                        n_os = ST_GRANTED;
                        n_ol = 1'b0;
                    end
                    n_pv    = 1'b1;
                    n_pb    = stk_rdata;
                    n_state = S_GPOP;
                end
            end
            S_GEND: begin
                if (out_free) begin
                    n_ov = 1'b1;
                    n_ol = 1'b1;
                    if (r_pv) begin
                        n_ob = BLOCK_W'(r_pb);
                        n_os = ST_GRANTED;
                    end else begin
                        n_ob = '0;
                        n_os = ST_EMPTY;
                    end
                    n_pv    = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fvld  <= '0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fvld  <= n_fvld;
            r_pv    <= n_pv;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk  <= n_blk;
        r_lvl  <= n_lvl;
        r_want <= n_want;
        r_fill <= n_fill;
        r_pb   <= n_pb;
        r_ob   <= n_ob;
        r_os   <= n_os;
        r_ol   <= n_ol;
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_ob;
    assign o_m_axis_tuser  = r_os;
    assign o_m_axis_tlast  = r_ol;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Wear-bucketed free block pool testbench
// Drives put and get items on the input stream and checks every result item
// against a behavioral copy of the per-level LIFO stacks: a directed table
// first, then random puts and gets, and finally the whole pool drained until
// gets come back empty.
// ----------------------------------------------------------------------------
module tb;
    import wbfbp_pkg::*;

    typedef struct packed {
        logic [BLOCK_W-1:0] blk;
        t_status            st;
        logic               last;
    } t_grant;

    typedef struct {
        logic               fn;
        logic [BLOCK_W-1:0] blk;
        logic [WEAR_W-1:0]  wl;
        logic [REQ_W-1:0]   rq;
        bit                 typed;
        t_grant             res;
    } t_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tuser = FUNC_PUT;
    logic                   m_tready = 1'b0;
    logic                   o_s_axis_tready;
    logic                   o_m_axis_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic [STATUS_W-1:0]    o_m_axis_tuser;
    logic                   o_m_axis_tlast;

    // Expected result items, oldest first.
    t_grant      pending_q[$];
    // Shadow copy of the pool.
    logic [BLOCK_W-1:0] level_stack[LEVELS_DEF][LEVEL_DEPTH_DEF];
    int unsigned        level_fill[LEVELS_DEF];

    bit  steady = 1'b0;
    int  fail_cnt = 0;
    int  n_put = 0;
    int  n_get = 0;
    int  n_seen[4] = '{0, 0, 0, 0};

    always #5 i_clk = ~i_clk;

    wear_bucketed_free_block_pool DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // Updates the shadow pool for one accepted item and, when asked,
    // queues the result items it causes.
    function automatic void allocate_or_free(input logic fn, input logic [BLOCK_W-1:0] blk,
                                             input logic [WEAR_W-1:0] wl,
                                             input logic [REQ_W-1:0] rq, input bit queue_it);
        int unsigned lvl;
        int unsigned want;
        int          got;
        t_grant      g;
        got = 0;
        if (fn == FUNC_PUT) begin
            lvl = (wl >= LEVELS_DEF) ? LEVELS_DEF - 1 : wl;
            g.blk  = '0;
            g.last = 1'b1;
            if (level_fill[lvl] >= LEVEL_DEPTH_DEF) begin
                g.st = ST_DROPPED;
            end else begin
                level_stack[lvl][level_fill[lvl]] = blk;
                level_fill[lvl]++;
                g.st = ST_STORED;
            end
            if (queue_it) pending_q.push_back(g);
            return;
        end
        want = (rq > MAX_REQUEST_DEF) ? MAX_REQUEST_DEF : rq;
        for (lvl = 0; lvl < LEVELS_DEF && want > 0; lvl++) begin
            while (want > 0 && level_fill[lvl] > 0) begin
                level_fill[lvl]--;
                g.blk  = level_stack[lvl][level_fill[lvl]];
                g.st   = ST_GRANTED;
                g.last = 1'b0;
                if (queue_it) pending_q.push_back(g);
                got++;
                want--;
            end
        end
        if (!queue_it) return;
        if (got == 0) begin
            g.blk  = '0;
            g.st   = ST_EMPTY;
            g.last = 1'b1;
            pending_q.push_back(g);
        end else begin
            pending_q[pending_q.size()-1].last = 1'b1;
        end
    endfunction

    function automatic int unsigned pool_total();
        int unsigned sum;
        sum = 0;
        foreach (level_fill[i]) sum += level_fill[i];
        return sum;
    endfunction

    // Offers one item, waits for it to be taken and then records what it
    // should cause. A typed row replaces the computed result.
    task automatic send_item(input logic fn, input logic [BLOCK_W-1:0] blk,
                             input logic [WEAR_W-1:0] wl, input logic [REQ_W-1:0] rq,
                             input bit typed, input t_grant res);
        if (!steady && $urandom_range(99) < 15) begin
            s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 15);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {{(IN_TDATA_W-REQ_W-WEAR_W-BLOCK_W){1'b0}}, rq, wl, blk};
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (fn == FUNC_PUT) n_put++; else n_get++;
        allocate_or_free(fn, blk, wl, rq, !typed);
        if (typed) pending_q.push_back(res);
    endtask

    task automatic send_random();
        logic [BLOCK_W-1:0] blk;
        logic [WEAR_W-1:0]  wl;
        logic [REQ_W-1:0]   rq;
        logic               fn;
        int                 pick;
        blk  = 16'($urandom);
        pick = $urandom_range(99);
        wl   = (pick < 50) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
        fn   = ($urandom_range(99) < 55) ? FUNC_PUT : FUNC_GET;
        rq   = 7'($urandom);
        if (fn == FUNC_GET) begin
            pick = $urandom_range(99);
            if (pick < 65)      rq = 7'($urandom_range(6, 1));
            else if (pick < 75) rq = '0;
            else if (pick < 90) rq = 7'($urandom_range(64, 7));
            else                rq = 7'($urandom_range(127, 65));
        end
        send_item(fn, blk, wl, rq, 1'b0, '0);
    endtask

    // Result side: random back-pressure and in-order comparison.
    always @(posedge i_clk) begin
        t_grant want;
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            n_seen[o_m_axis_tuser]++;
            if (pending_q.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("unexpected result item: block %h status %0d last %0d",
                             o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
            end else begin
                want = pending_q.pop_front();
                if (o_m_axis_tdata !== want.blk || o_m_axis_tuser !== want.st
                    || o_m_axis_tlast !== want.last) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("mismatch: block %h/%h status %0d/%0d last %0d/%0d (exp/got)",
                                 want.blk, o_m_axis_tdata, want.st, o_m_axis_tuser,
                                 want.last, o_m_axis_tlast);
                end
            end
        end
        m_tready <= steady || ($urandom_range(99) >= 15);
    end

    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        t_row   dir[$];
        t_grant empty_res;
        t_grant stored_res;
        int     k;
        empty_res   = '{blk: '0, st: ST_EMPTY, last: 1'b1};
        stored_res  = '{blk: '0, st: ST_STORED, last: 1'b1};
        foreach (level_fill[i]) level_fill[i] = 0;

        // Gets on the empty pool, including a zero request and an oversized one.
        dir.push_back('{FUNC_GET, 16'h0000, 4'd0,  7'd1,   1'b1, empty_res});
        dir.push_back('{FUNC_GET, 16'hFFFF, 4'hF,  7'd0,   1'b1, empty_res});
        dir.push_back('{FUNC_GET, 16'h0000, 4'd0,  7'd127, 1'b1, empty_res});
        dir.push_back('{FUNC_PUT, 16'hFFFF, 4'd15, 7'd127, 1'b1, stored_res});
        dir.push_back('{FUNC_PUT, 16'h0000, 4'd0,  7'd0,   1'b1, stored_res});
        dir.push_back('{FUNC_PUT, 16'h1234, 4'd0,  7'd0,   1'b1, stored_res});
        dir.push_back('{FUNC_PUT, 16'hA5A5, 4'd7,  7'd0,   1'b1, stored_res});
        dir.push_back('{FUNC_PUT, 16'h5A5A, 4'd3,  7'd0,   1'b1, stored_res});
        dir.push_back('{FUNC_GET, 16'h0000, 4'd0,  7'd1,   1'b0, empty_res});
        // A zero request grants nothing even with blocks in the pool.
        dir.push_back('{FUNC_GET, 16'h0000, 4'd0,  7'd0,   1'b1, empty_res});
        dir.push_back('{FUNC_GET, 16'h0000, 4'd0,  7'd2,   1'b0, empty_res});
        // Oversized request that runs the pool dry: partial grant.
        dir.push_back('{FUNC_GET, 16'h0000, 4'd0,  7'd127, 1'b0, empty_res});
        dir.push_back('{FUNC_GET, 16'h0000, 4'd0,  7'd64,  1'b1, empty_res});
        dir.push_back('{FUNC_PUT, 16'h8001, 4'd1,  7'd0,   1'b1, stored_res});
        dir.push_back('{FUNC_PUT, 16'h4002, 4'd2,  7'd0,   1'b1, stored_res});
        dir.push_back('{FUNC_PUT, 16'h2004, 4'd4,  7'd0,   1'b1, stored_res});
        dir.push_back('{FUNC_PUT, 16'h1008, 4'd8,  7'd0,   1'b1, stored_res});
        dir.push_back('{FUNC_PUT, 16'h0810, 4'd8,  7'd0,   1'b1, stored_res});
        dir.push_back('{FUNC_GET, 16'h0000, 4'd0,  7'd3,   1'b0, empty_res});
        dir.push_back('{FUNC_GET, 16'h0000, 4'd0,  7'd65,  1'b0, empty_res});
        dir.push_back('{FUNC_PUT, 16'h00FF, 4'd15, 7'd0,   1'b1, stored_res});
        dir.push_back('{FUNC_GET, 16'h0000, 4'd0,  7'd64,  1'b0, empty_res});

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir[i])
            send_item(dir[i].fn, dir[i].blk, dir[i].wl, dir[i].rq, dir[i].typed, dir[i].res);

        for (k = 0; k < 85; k++) begin
            steady = (k >= 30 && k < 60);
            if (k == 75) begin
                // Hold off until the block has returned everything owed.
                s_tvalid <= 1'b0;
                while (pending_q.size() != 0) @(posedge i_clk);
            end
            send_random();
        end
        steady = 1'b0;

        // Drain the whole pool with maximal gets, then one more on empty.
        while (pool_total() != 0)
            send_item(FUNC_GET, 16'($urandom), 4'($urandom), 7'd127, 1'b0, '0);
        send_item(FUNC_GET, 16'($urandom), 4'($urandom), 7'd127, 1'b1, empty_res);
        s_tvalid <= 1'b0;

        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Sent %0d puts and %0d gets.", n_put, n_get);
        $display("Results seen: %0d stored, %0d granted, %0d dropped, %0d empty; %0d errors.",
                 n_seen[ST_STORED], n_seen[ST_GRANTED], n_seen[ST_DROPPED], n_seen[ST_EMPTY],
                 fail_cnt);
        if (fail_cnt == 0 && pending_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

/* files.f */
hw/rtl/wbfbp_pkg.sv
hw/rtl/wbfbp_ram.sv
hw/rtl/wear_bucketed_free_block_pool.sv
tb/sv/tb.sv
